/* sv/kdsl_pkg.sv */
// ----------------------------------------------------------------------------
// kdsl_pkg
// Shared types and constants for the key debouncer with short/long press.
// ----------------------------------------------------------------------------
package kdsl_pkg;

  // Timer and register widths
  localparam int TIMER_BITS = 16;
  localparam int CFG_W      = 16;
  localparam int CMP_W      = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

  // Stream payload widths
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 8;

  // Register map
  localparam logic CFG_IDX_DEBOUNCE = 1'b0;
  localparam logic CFG_IDX_LONG     = 1'b1;

  // Register reset values
  localparam logic [CFG_W-1:0] DEBOUNCE_RST = CFG_W'(20);
  localparam logic [CFG_W-1:0] LONG_RST     = CFG_W'(800);

  // Reported phase codes
  localparam logic [1:0] PHASE_IDLE       = 2'd0;
  localparam logic [1:0] PHASE_PRESS_DB   = 2'd1;
  localparam logic [1:0] PHASE_HELD       = 2'd2;
  localparam logic [1:0] PHASE_RELEASE_DB = 2'd3;

  typedef logic [TIMER_BITS-1:0] timer_t;
  typedef logic [CFG_W-1:0]      cfg_word_t;

  // One-hot phase machine
  typedef enum logic [3:0] {
    ST_IDLE       = 4'b0001,
    ST_PRESS_DB   = 4'b0010,
    ST_HELD       = 4'b0100,
    ST_RELEASE_DB = 4'b1000
  } phase_t;

  // One input beat
  typedef struct packed {
    logic key_edge;
    logic key_down;
  } key_in_t;

  // One result beat
  typedef struct packed {
    logic [1:0] key_phase;
    logic       long_press;
    logic       short_press;
  } key_res_t;

  // Configuration values seen by the phase machine
  typedef struct packed {
    cfg_word_t debounce_ticks;
    cfg_word_t long_press_ticks;
  } key_cfg_t;

endpackage

/* sv/kdsl_cfg.sv */
// ----------------------------------------------------------------------------
// kdsl_cfg
// Configuration register file: debounce and long-press intervals.
// ----------------------------------------------------------------------------
module kdsl_cfg (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  kdsl_pkg::cfg_word_t    cfg_wdata,
  output kdsl_pkg::key_cfg_t     cfg
);
  import kdsl_pkg::*;

  cfg_word_t debounce_r;
  cfg_word_t long_r;

  // Write the selected register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RST;
      long_r     <= LONG_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_DEBOUNCE: debounce_r <= cfg_wdata;
        CFG_IDX_LONG:     long_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg.debounce_ticks   = debounce_r;
  assign cfg.long_press_ticks = long_r;

endmodule

/* sv/kdsl_fsm.sv */
// ----------------------------------------------------------------------------
// kdsl_fsm
// Phase machine and timers; computes one result per accepted tick.
// ----------------------------------------------------------------------------
module kdsl_fsm (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  kdsl_pkg::key_in_t    key_in,
  input  kdsl_pkg::key_cfg_t   cfg,
  output kdsl_pkg::key_res_t   res
);
  import kdsl_pkg::*;

  localparam timer_t TIMER_MAX = '1;

  phase_t phase_r, phase_nxt;
  timer_t chg_r, chg_nxt;
  timer_t prs_r, prs_nxt;
  logic   long_sent_r, long_sent_nxt;
  logic   edge_wait_r, edge_wait_nxt;

  timer_t chg_inc;
  timer_t prs_inc;
  logic   edge_pend;
  logic   db_done;
  logic   long_due;
  logic   short_ev;
  logic   long_ev;

  // Saturating advance of both timers, latch the edge flag
  assign chg_inc   = (chg_r == TIMER_MAX) ? chg_r : chg_r + timer_t'(1);
  assign prs_inc   = (prs_r == TIMER_MAX) ? prs_r : prs_r + timer_t'(1);
  assign edge_pend = edge_wait_r | key_in.key_edge;

  // Threshold compares on a common width
  assign db_done  = CMP_W'(chg_inc) >= CMP_W'(cfg.debounce_ticks);
  assign long_due = CMP_W'(prs_inc) >= CMP_W'(cfg.long_press_ticks);

  // Next phase and events
  always_comb begin
    phase_nxt     = phase_r;
    chg_nxt       = chg_inc;
    prs_nxt       = prs_inc;
    long_sent_nxt = long_sent_r;
    edge_wait_nxt = edge_pend;
    short_ev      = 1'b0;
    long_ev       = 1'b0;
    unique case (phase_r)
      ST_IDLE: begin
        if (edge_pend) begin
          edge_wait_nxt = 1'b0;
          chg_nxt       = '0;
          phase_nxt     = ST_PRESS_DB;
        end
      end
      ST_PRESS_DB: begin
        if (!key_in.key_down) begin
          phase_nxt = ST_IDLE;
        end else if (db_done) begin
          prs_nxt       = '0;
          long_sent_nxt = 1'b0;
          phase_nxt     = ST_HELD;
        end
      end
      ST_HELD: begin
        if (!key_in.key_down) begin
          chg_nxt   = '0;
          phase_nxt = ST_RELEASE_DB;
        end else if (!long_sent_r && long_due) begin
          long_ev       = 1'b1;
          long_sent_nxt = 1'b1;
        end
      end
      ST_RELEASE_DB: begin
        if (key_in.key_down) begin
          phase_nxt = ST_HELD;
        end else if (db_done) begin
          short_ev  = !long_sent_r;
          phase_nxt = ST_IDLE;
        end
      end
      default: begin
        phase_nxt = ST_IDLE;
      end
    endcase
  end

  // Map the one-hot phase to the reported code
  always_comb begin
    res.short_press = short_ev;
    res.long_press  = long_ev;
    unique case (phase_nxt)
      ST_IDLE:       res.key_phase = PHASE_IDLE;
      ST_PRESS_DB:   res.key_phase = PHASE_PRESS_DB;
      ST_HELD:       res.key_phase = PHASE_HELD;
      ST_RELEASE_DB: res.key_phase = PHASE_RELEASE_DB;
      default:       res.key_phase = PHASE_IDLE;
    endcase
  end

  // Commit state on each accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= ST_IDLE;
      chg_r       <= '0;
      prs_r       <= '0;
      long_sent_r <= 1'b0;
      edge_wait_r <= 1'b0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      chg_r       <= chg_nxt;
      prs_r       <= prs_nxt;
      long_sent_r <= long_sent_nxt;
      edge_wait_r <= edge_wait_nxt;
    end
  end

endmodule

/* sv/kdsl_out_reg.sv */
// ----------------------------------------------------------------------------
// kdsl_out_reg
// Result register on the master side; takes a new beat whenever it can drain.
// ----------------------------------------------------------------------------
module kdsl_out_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  kdsl_pkg::key_res_t   res,
  output logic                 can_load,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output kdsl_pkg::key_res_t   out_res
);
  import kdsl_pkg::*;

  logic     valid_r;
  key_res_t data_r;

  // Free when empty or when the held beat leaves this cycle
  assign can_load   = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_res    = data_r;

  // Hold valid until the beat is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  // Capture the payload
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

endmodule

/* sv/key_debounce_short_long_press_core.sv */
// ----------------------------------------------------------------------------
// key_debounce_short_long_press_core
// Key debouncer with short-press and long-press detection, one tick per beat.
// ----------------------------------------------------------------------------
// Result beats are registered: each shows in the cycle after its input beat.
// Throughput: one input beat per cycle; the single result register drains and
// refills in the same cycle, so only output backpressure slows intake.
// Reset (synchronous, rst_n low): phase idle, timers and flags cleared,
// debounce interval 20 ticks, long-press interval 800 ticks, output empty.
// ----------------------------------------------------------------------------
module key_debounce_short_long_press_core (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [kdsl_pkg::IN_DATA_W-1:0]  in_tdata,   // [0] key_down, [1] key_edge
  // Result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [kdsl_pkg::OUT_DATA_W-1:0] out_tdata,  // [0] short_press, [1] long_press,
                                                      // [3:2] key_phase
  // Configuration write port
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [kdsl_pkg::CFG_W-1:0]      cfg_wdata
);
  import kdsl_pkg::*;

  key_in_t  key_in;
  key_cfg_t cfg;
  key_res_t res;
  key_res_t out_res;
  logic     in_fire;
  logic     can_load;

  // Unpack the input beat
  assign key_in.key_down = in_tdata[0];
  assign key_in.key_edge = in_tdata[1];

  assign in_tready = can_load;
  assign in_fire   = in_tvalid && can_load;

  kdsl_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  kdsl_fsm u_fsm (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (in_fire),
    .key_in (key_in),
    .cfg    (cfg),
    .res    (res)
  );

  kdsl_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_fire),
    .res        (res),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  // Pack the result beat, zero-filled to a whole byte
  assign out_tdata = {{(OUT_DATA_W - 4){1'b0}}, out_res.key_phase,
                      out_res.long_press, out_res.short_press};

endmodule

/* dv/key_debounce_short_long_press_core_tb.sv */
// ----------------------------------------------------------------------------
// key_debounce_short_long_press_core_tb
// Self-checking bench for the key debouncer with short and long press events.
// Every tick beat is run through a local phase predictor. Each result beat is
// compared field by field with the oldest prediction. Traffic is bursty on
// the input side, and the output side stalls on its own schedule.
// ----------------------------------------------------------------------------
module key_debounce_short_long_press_core_tb;
  import kdsl_pkg::*;

  localparam int unsigned LONG_HOLD   = 400;   // output hold-off, in cycles
  localparam int unsigned STALL_LIMIT = 3000;  // cycles without any beat moving
  localparam int unsigned RANDOM_TICKS = 770;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;        // [0] key_down, [1] key_edge
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;            // [0] short_press, [1] long_press,
                                               // [3:2] key_phase
  logic                  cfg_we = 1'b0;
  logic                  cfg_index = 1'b0;
  logic [CFG_W-1:0]      cfg_wdata = '0;

  key_debounce_short_long_press_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Predictor state and its copy of the interval registers
  logic [1:0] pred_phase   = PHASE_IDLE;
  timer_t     settle_cnt   = '0;
  timer_t     hold_cnt     = '0;
  logic       long_fired   = 1'b0;
  logic       edge_latched = 1'b0;
  cfg_word_t  db_limit     = DEBOUNCE_RST;
  cfg_word_t  long_limit   = LONG_RST;

  key_res_t    expected_events[$];
  int unsigned mismatches = 0;
  int unsigned ticks_sent = 0;
  int unsigned results_checked = 0;
  int unsigned shorts_seen = 0;
  int unsigned longs_seen = 0;
  int unsigned settings_used = 1;
  int unsigned burst_left = 0;
  bit          hold_req = 1'b0;

  // Advance the predicted key machine by one tick and return its result beat
  function automatic key_res_t predict_key_tick(key_in_t beat);
    key_res_t res;
    res = '0;
    if (beat.key_edge) edge_latched = 1'b1;
    if (settle_cnt != '1) settle_cnt++;
    if (hold_cnt != '1) hold_cnt++;
    case (pred_phase)
      PHASE_IDLE: begin
        if (edge_latched) begin
          edge_latched = 1'b0;
          settle_cnt = '0;
          pred_phase = PHASE_PRESS_DB;
        end
      end
      PHASE_PRESS_DB: begin
        if (!beat.key_down) begin
          pred_phase = PHASE_IDLE;
        end else if (settle_cnt >= db_limit) begin
          hold_cnt = '0;
          long_fired = 1'b0;
          pred_phase = PHASE_HELD;
        end
      end
      PHASE_HELD: begin
        if (!beat.key_down) begin
          settle_cnt = '0;
          pred_phase = PHASE_RELEASE_DB;
        end else if (!long_fired && hold_cnt >= long_limit) begin
          res.long_press = 1'b1;
          long_fired = 1'b1;
        end
      end
      default: begin
        if (beat.key_down) begin
          pred_phase = PHASE_HELD;
        end else if (settle_cnt >= db_limit) begin
          res.short_press = !long_fired;
          pred_phase = PHASE_IDLE;
        end
      end
    endcase
    res.key_phase = pred_phase;
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // Compare result beats first, then queue the prediction for a new tick beat
  always @(posedge clk) begin
    key_res_t got;
    key_res_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[$bits(key_res_t)-1:0];
        if (expected_events.size() == 0) begin
          report_mismatch($sformatf("result beat 0x%0h with nothing pending", out_tdata));
        end else begin
          want = expected_events.pop_front();
          if (got.short_press !== want.short_press)
            report_mismatch($sformatf("short_press got %b expected %b",
                                      got.short_press, want.short_press));
          if (got.long_press !== want.long_press)
            report_mismatch($sformatf("long_press got %b expected %b",
                                      got.long_press, want.long_press));
          if (got.key_phase !== want.key_phase)
            report_mismatch($sformatf("key_phase got %0d expected %0d",
                                      got.key_phase, want.key_phase));
          results_checked++;
          if (want.short_press) shorts_seen++;
          if (want.long_press) longs_seen++;
        end
      end
      if (in_tvalid && in_tready)
        expected_events.push_back(predict_key_tick(key_in_t'(in_tdata[1:0])));
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk) begin
    int unsigned quiet;
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  // Result side: switch between stall patterns, honor a requested long hold-off
  initial begin : rx_side
    int unsigned mode;
    int unsigned mode_left;
    int unsigned cyc;
    mode = 0;
    mode_left = 0;
    cyc = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 300);
        end
        mode_left--;
        cyc++;
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 3) != 0);
          2: out_tready <= ((cyc % 4) != 3);
          default: out_tready <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  // Offer one tick beat; open a random gap between bursts; wait for acceptance
  task automatic send_tick(bit down, bit edge_seen);
    key_in_t     beat;
    int unsigned gap;
    beat.key_down = down;
    beat.key_edge = edge_seen;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= {{(IN_DATA_W-$bits(key_in_t)){1'b0}}, beat};
    do @(posedge clk); while (!in_tready);
    ticks_sent++;
  endtask

  // Stop offering ticks and wait for every pending result
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, cfg_word_t value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_IDX_DEBOUNCE) db_limit = value;
    else long_limit = value;
  endtask

  task automatic set_intervals(cfg_word_t db, cfg_word_t lp);
    drain_results();
    write_reg(CFG_IDX_DEBOUNCE, db);
    write_reg(CFG_IDX_LONG, lp);
    settings_used++;
  endtask

  // One press with random timing around the current intervals, bounces included
  task automatic press_sequence();
    int unsigned settle;
    int unsigned hold;
    int unsigned rel;
    send_tick(1'($urandom_range(0, 1)), 1'b1);
    settle = ($urandom_range(0, 4) == 0) ? $urandom_range(0, db_limit)
                                         : db_limit + $urandom_range(0, 2);
    repeat (settle) send_tick(1'b1, $urandom_range(0, 15) == 0);
    hold = ($urandom_range(0, 1) == 0) ? $urandom_range(0, long_limit)
                                       : long_limit + $urandom_range(0, 8);
    repeat (hold) begin
      if ($urandom_range(0, 9) == 0) send_tick(1'b0, 1'b0);
      else send_tick(1'b1, $urandom_range(0, 15) == 0);
    end
    rel = ($urandom_range(0, 4) == 0) ? $urandom_range(0, db_limit)
                                      : db_limit + $urandom_range(0, 3);
    repeat (rel) send_tick(1'b0, $urandom_range(0, 15) == 0);
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(1, 12))
      send_tick(1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
  endtask

  // Reset intervals: one short press and one long press
  task automatic test_reset_values();
    send_tick(1'b1, 1'b1);
    repeat (20 + 30) send_tick(1'b1, 1'b0);
    repeat (21) send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);
    repeat (20 + 805) send_tick(1'b1, 1'b0);
    repeat (21) send_tick(1'b0, 1'b0);
  endtask

  // Hand-built walk: aborted press, bounce on release, edge latched while busy,
  // short press, long press with no short after it
  task automatic test_directed_sequence();
    bit [1:0] steps [24] = '{2'b00, 2'b01, 2'b10, 2'b00, 2'b11, 2'b01, 2'b11, 2'b00,
                             2'b01, 2'b01, 2'b00, 2'b00, 2'b00, 2'b00, 2'b01, 2'b01,
                             2'b01, 2'b01, 2'b01, 2'b01, 2'b01, 2'b00, 2'b00, 2'b00};
    set_intervals(16'd2, 16'd4);
    foreach (steps[i]) send_tick(steps[i][0], steps[i][1]);
  endtask

  // Zero intervals: each decision is taken on the first tick in its phase
  task automatic test_zero_intervals();
    bit [1:0] steps [9] = '{2'b11, 2'b01, 2'b01, 2'b00, 2'b00, 2'b10, 2'b01, 2'b00, 2'b00};
    set_intervals(16'd0, 16'd0);
    foreach (steps[i]) send_tick(steps[i][0], steps[i][1]);
  endtask

  // Hold the result side off while ticks keep coming, so intake stalls
  task automatic test_backpressure();
    set_intervals(16'd3, 16'd10);
    hold_req = 1'b1;
    repeat (4) press_sequence();
  endtask

  // Widest intervals: a held key never reaches the long press, a pressed key
  // never leaves press debounce
  task automatic test_max_intervals();
    set_intervals(16'd1, 16'hFFFF);
    send_tick(1'b1, 1'b1);
    repeat (60) send_tick(1'b1, 1'b0);
    repeat (3) send_tick(1'b0, 1'b0);
    set_intervals(16'hFFFF, 16'd1);
    send_tick(1'b1, 1'b1);
    repeat (40) send_tick(1'b1, 1'b0);
    repeat (40) send_tick(1'b0, 1'b0);
  endtask

  // Mostly complete presses with random timing, some noise, changing intervals
  task automatic test_random_presses();
    int unsigned stop_at;
    int unsigned phase_end;
    stop_at = ticks_sent + RANDOM_TICKS;
    while (ticks_sent < stop_at) begin
      case ($urandom_range(0, 5))
        0: set_intervals(16'd1, 16'd1);
        1: set_intervals(16'd0, 16'($urandom_range(0, 3)));
        2: set_intervals(16'($urandom_range(1, 4)), 16'($urandom_range(40, 120)));
        default: set_intervals(16'($urandom_range(1, 8)), 16'($urandom_range(1, 40)));
      endcase
      phase_end = ticks_sent + $urandom_range(150, 350);
      while (ticks_sent < phase_end && ticks_sent < stop_at) begin
        if ($urandom_range(0, 6) != 0) press_sequence();
        else noise_burst();
      end
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    test_reset_values();
    test_directed_sequence();
    test_zero_intervals();
    test_backpressure();
    test_max_intervals();
    test_random_presses();
    drain_results();
    repeat (4) @(posedge clk);
    $display("Sent %0d key ticks under %0d interval settings, incl. a %0d-cycle output stall.",
             ticks_sent, settings_used, LONG_HOLD);
    $display("Checked %0d result beats: %0d short and %0d long presses, %0d mismatches.",
             results_checked, shorts_seen, longs_seen, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
